// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of the line text log buffer.
// No dependencies; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define LTLB_ASSERT_CLK(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
		else $error(msg);

// Assertion on the block clock clk and reset arst_n.
`define LTLB_ASSERT(lbl, prop, msg) `LTLB_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// File: rtl/core/ltlb_pkg.sv
// Shared constants, request/result types and helper functions of the line text log buffer.
// No dependencies; used by every module of the block.
package ltlb_pkg;

	localparam int LOG_CAPACITY = 1024;
	localparam int PTR_W        = $clog2(LOG_CAPACITY);
	localparam int LEN_W        = $clog2(LOG_CAPACITY + 1);
	localparam int HALF_DROP    = LOG_CAPACITY / 2;

	localparam int CHAR_W = 8;
	localparam int LINE_W = 11;
	localparam int OFF_W  = 10;
	localparam int LCMP_W = (LEN_W > LINE_W) ? LEN_W : LINE_W;
	localparam int COL_W  = (LEN_W > OFF_W) ? LEN_W : OFF_W;

	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [CHAR_W-1:0] char_in;
		logic [LINE_W-1:0] line_number;
		logic [OFF_W-1:0]  char_offset;
	} req_t;

	typedef struct packed {
		logic [LINE_W-1:0] line_count;
		logic [CHAR_W-1:0] data_char;
		logic              char_valid;
		logic              stored;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [CHAR_W-1:0] wdata;
		logic [PTR_W-1:0]  raddr;
	} mem_req_t;

	// Ring index of the character at position ofs from the head; ofs stays below capacity.
	function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] head,
			input logic [LEN_W-1:0] ofs);
		logic [LEN_W:0] sum;
		sum = (LEN_W+1)'(head) + (LEN_W+1)'(ofs);
		if (sum >= (LEN_W+1)'(LOG_CAPACITY)) begin
			sum = sum - (LEN_W+1)'(LOG_CAPACITY);
		end
		return PTR_W'(sum);
	endfunction

	// Tab, newline and every byte from 0x20 upward are kept; other control bytes are ignored.
	function automatic logic char_ok(input logic [CHAR_W-1:0] ch);
		return (ch == CH_TAB) || (ch == CH_NEWLINE) || (ch >= CH_SPACE);
	endfunction

endpackage

// File: rtl/core/ltlb_ring_ram.sv
// Text ring storage: one write port and one read port with registered read data.
// Depends on ltlb_pkg for the capacity and the memory request struct.
module ltlb_ring_ram (
	input  logic                              clk,
	input  ltlb_pkg::mem_req_t                mem,
	output logic [ltlb_pkg::CHAR_W-1:0]       rdata
);

	logic [ltlb_pkg::CHAR_W-1:0] ring_mem [ltlb_pkg::LOG_CAPACITY];
	logic [ltlb_pkg::CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem.we) begin
			ring_mem[mem.waddr] <= mem.wdata;
		end
		rdata_q <= ring_mem[mem.raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/ltlb_ctrl.sv
// Request sequencer of the line text log buffer: log pointers, line scan and drop logic.
// Depends on ltlb_pkg; drives the ring memory through a mem_req_t bundle.
module ltlb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  ltlb_pkg::req_t              req,
	output logic                        busy,
	output logic                        done,
	output ltlb_pkg::rsp_t              rsp,
	output ltlb_pkg::mem_req_t          mem,
	input  logic [ltlb_pkg::CHAR_W-1:0] rdata
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RSCAN = 4'b0010,
		ST_FSCAN = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	state_t                        state_q, state_d;
	logic [ltlb_pkg::PTR_W-1:0]    head_q, head_d;
	logic [ltlb_pkg::LEN_W-1:0]    len_q, len_d;
	logic [ltlb_pkg::LEN_W-1:0]    nl_q, nl_d;
	logic                          last_nl_q, last_nl_d;
	logic                          done_q, done_d;
	logic                          pend_s1, pend_d;
	ltlb_pkg::rsp_t                rsp_q, rsp_d;
	logic [ltlb_pkg::CHAR_W-1:0]   ch_q, ch_d;
	logic [ltlb_pkg::LINE_W-1:0]   line_q, line_d;
	logic [ltlb_pkg::OFF_W-1:0]    off_q, off_d;
	logic [ltlb_pkg::LEN_W-1:0]    idx_q, idx_d;
	logic [ltlb_pkg::PTR_W-1:0]    pos_s1, pos_d;
	logic [ltlb_pkg::LEN_W-1:0]    pidx_s1, pidx_d;
	logic [ltlb_pkg::LCMP_W-1:0]   cur_line_q, cur_line_d;
	logic [ltlb_pkg::COL_W-1:0]    col_q, col_d;

	logic                          accept, full, scanning, issue, eot, cur_nl, in_nl;
	logic [ltlb_pkg::LEN_W-1:0]    ofs_sel;
	logic [ltlb_pkg::PTR_W-1:0]    addr, half_head, next_head;
	logic [ltlb_pkg::LINE_W-1:0]   count_now, count_app;

	assign accept   = start && (state_q == ST_IDLE);
	assign full     = (len_q == ltlb_pkg::LEN_W'(ltlb_pkg::LOG_CAPACITY));
	assign scanning = (state_q == ST_RSCAN) || (state_q == ST_FSCAN);
	assign issue    = scanning && (idx_q < len_q);
	assign eot      = !pend_s1 && (idx_q >= len_q);
	assign cur_nl   = (rdata == ltlb_pkg::CH_NEWLINE);
	assign in_nl    = (req.char_in == ltlb_pkg::CH_NEWLINE);

	assign ofs_sel   = scanning ? idx_q : len_q;
	assign addr      = ltlb_pkg::ring_pos(head_q, ofs_sel);
	assign half_head = ltlb_pkg::ring_pos(head_q, ltlb_pkg::LEN_W'(ltlb_pkg::HALF_DROP));
	assign next_head = (pos_s1 == ltlb_pkg::PTR_W'(ltlb_pkg::LOG_CAPACITY - 1)) ?
			'0 : pos_s1 + ltlb_pkg::PTR_W'(1);

	// An unterminated last line counts as a line; after an append the count is always nl + 1.
	assign count_now = ltlb_pkg::LINE_W'((ltlb_pkg::LEN_W+1)'(nl_q) +
			(ltlb_pkg::LEN_W+1)'((len_q != '0) && !last_nl_q));
	assign count_app = ltlb_pkg::LINE_W'((ltlb_pkg::LEN_W+1)'(nl_q) + (ltlb_pkg::LEN_W+1)'(1));

	assign mem.we    = (accept && (req.req_type == ltlb_pkg::REQ_APPEND) &&
			ltlb_pkg::char_ok(req.char_in) && !full) || (state_q == ST_WRITE);
	assign mem.waddr = addr;
	assign mem.wdata = (state_q == ST_WRITE) ? ch_q : req.char_in;
	assign mem.raddr = addr;

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		len_d      = len_q;
		nl_d       = nl_q;
		last_nl_d  = last_nl_q;
		done_d     = 1'b0;
		pend_d     = issue;
		rsp_d      = rsp_q;
		ch_d       = ch_q;
		line_d     = line_q;
		off_d      = off_q;
		idx_d      = issue ? idx_q + ltlb_pkg::LEN_W'(1) : idx_q;
		pos_d      = addr;
		pidx_d     = idx_q;
		cur_line_d = cur_line_q;
		col_d      = col_q;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ch_d       = req.char_in;
					line_d     = req.line_number;
					off_d      = req.char_offset;
					idx_d      = '0;
					cur_line_d = '0;
					col_d      = '0;
					if (req.req_type == ltlb_pkg::REQ_READ) begin
						state_d = ST_RSCAN;
					end else if (!ltlb_pkg::char_ok(req.char_in)) begin
						done_d = 1'b1;
						rsp_d  = '{line_count: count_now, data_char: '0,
								char_valid: 1'b0, stored: 1'b0};
					end else if (!full) begin
						len_d     = len_q + ltlb_pkg::LEN_W'(1);
						nl_d      = nl_q + ltlb_pkg::LEN_W'(in_nl);
						last_nl_d = in_nl;
						done_d    = 1'b1;
						rsp_d     = '{line_count: count_app, data_char: '0,
								char_valid: 1'b0, stored: 1'b1};
					end else if (nl_q == '0) begin
						head_d  = half_head;
						len_d   = len_q - ltlb_pkg::LEN_W'(ltlb_pkg::HALF_DROP);
						state_d = ST_WRITE;
					end else begin
						state_d = ST_FSCAN;
					end
				end
			end
			ST_RSCAN: begin
				if (pend_s1) begin
					if (cur_line_q == ltlb_pkg::LCMP_W'(line_q)) begin
						if (cur_nl) begin
							state_d = ST_IDLE;
							done_d  = 1'b1;
							pend_d  = 1'b0;
							rsp_d   = '{line_count: count_now, data_char: '0,
									char_valid: 1'b0, stored: 1'b0};
						end else if (col_q == ltlb_pkg::COL_W'(off_q)) begin
							state_d = ST_IDLE;
							done_d  = 1'b1;
							pend_d  = 1'b0;
							rsp_d   = '{line_count: count_now, data_char: rdata,
									char_valid: 1'b1, stored: 1'b0};
						end else begin
							col_d = col_q + ltlb_pkg::COL_W'(1);
						end
					end else if (cur_nl) begin
						cur_line_d = cur_line_q + ltlb_pkg::LCMP_W'(1);
					end
				end else if (eot) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
					rsp_d   = '{line_count: count_now, data_char: '0,
							char_valid: 1'b0, stored: 1'b0};
				end
			end
			ST_FSCAN: begin
				if (pend_s1 && cur_nl) begin
					// First newline found: drop through it unless it ends the log.
					if (pidx_s1 < len_q - ltlb_pkg::LEN_W'(1)) begin
						head_d = next_head;
						len_d  = len_q - (pidx_s1 + ltlb_pkg::LEN_W'(1));
						nl_d   = nl_q - ltlb_pkg::LEN_W'(1);
					end else begin
						head_d = half_head;
						len_d  = len_q - ltlb_pkg::LEN_W'(ltlb_pkg::HALF_DROP);
					end
					state_d = ST_WRITE;
					pend_d  = 1'b0;
				end else if (eot) begin
					head_d  = half_head;
					len_d   = len_q - ltlb_pkg::LEN_W'(ltlb_pkg::HALF_DROP);
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				len_d     = len_q + ltlb_pkg::LEN_W'(1);
				nl_d      = nl_q + ltlb_pkg::LEN_W'(ch_q == ltlb_pkg::CH_NEWLINE);
				last_nl_d = (ch_q == ltlb_pkg::CH_NEWLINE);
				done_d    = 1'b1;
				state_d   = ST_IDLE;
				rsp_d     = '{line_count: count_app, data_char: '0,
						char_valid: 1'b0, stored: 1'b1};
			end
			default: begin
				state_d = ST_IDLE;
				pend_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			len_q     <= '0;
			nl_q      <= '0;
			last_nl_q <= 1'b0;
			done_q    <= 1'b0;
			pend_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			len_q     <= len_d;
			nl_q      <= nl_d;
			last_nl_q <= last_nl_d;
			done_q    <= done_d;
			pend_s1   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q      <= rsp_d;
		ch_q       <= ch_d;
		line_q     <= line_d;
		off_q      <= off_d;
		idx_q      <= idx_d;
		pos_s1     <= pos_d;
		pidx_s1    <= pidx_d;
		cur_line_q <= cur_line_d;
		col_q      <= col_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: rtl/core/line_text_log_buffer.sv
// Top level of the line text log buffer: request sequencer plus text ring memory.
// Depends on ltlb_pkg, ltlb_ctrl and ltlb_ring_ram.

// A request is taken at a rising edge where start is high and busy is low; its
// result appears on rsp, flagged by done for exactly one cycle, and must be
// captured then; rsp holds it only until the next result. An append that is
// rejected, or that fits without dropping text, completes straight from idle
// and never raises busy. An append into a full log walks the text to its first
// newline, one character per cycle through the single read port of the ring
// memory; when the log holds no newline at all, half the text is dropped with
// no walk. A read request walks the text from the start to the requested
// character or to the end of the named line, also one character per cycle, up
// to the whole of a full log of 1024 bytes. No clearing pass is needed after
// reset: only bytes inside the current text are ever used.
module line_text_log_buffer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ltlb_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output ltlb_pkg::rsp_t rsp
);

	// The memory bundle carries both the write of an append and the scan reads.
	// Writes happen only while idle or in the write step, and read data is used
	// only during a scan, so the two never touch the same entry in overlapping
	// cycles and no forwarding path is required.
	ltlb_pkg::mem_req_t          mem;
	logic [ltlb_pkg::CHAR_W-1:0] rdata;

	// The sequencer owns the head pointer, length and newline count, and walks
	// the text for line lookups and for the drop decision on a full log.
	ltlb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp),
		.mem    (mem),
		.rdata  (rdata)
	);

	// The ring memory holds the log bytes; read data is registered and arrives in
	// the cycle after the address, where the sequencer processes it.
	ltlb_ring_ram u_ring (
		.clk   (clk),
		.mem   (mem),
		.rdata (rdata)
	);

endmodule

// File: rtl/core/ltlb_checker.sv
// Port-level assertions for the line text log buffer, bound to its top level.
// Depends on ltlb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ltlb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input ltlb_pkg::req_t req,
	input logic           busy,
	input logic           done,
	input ltlb_pkg::rsp_t rsp
);

	// A read always needs a walk of the text, so the block is busy right after it.
	`LTLB_ASSERT(a_read_busy, start && !busy && (req.req_type == ltlb_pkg::REQ_READ) |=> busy, "read request did not start a scan")

	// Leaving the busy state always delivers the result of that request.
	`LTLB_ASSERT(a_fall_done, $fell(busy) |-> done, "busy dropped without a result")

	// No result appears without a request in flight or just taken.
	`LTLB_ASSERT(a_done_cause, done |-> $past(busy) || $past(start), "result without a request")

	// After a byte is appended the log holds at least one line.
	`LTLB_ASSERT(a_store_count, done && rsp.stored |-> rsp.line_count != 11'd0, "stored byte but zero lines")

	// A character that does not exist reads as zero.
	`LTLB_ASSERT(a_invalid_zero, done && !rsp.char_valid |-> rsp.data_char == 8'd0, "invalid read returned data")

endmodule

bind line_text_log_buffer ltlb_checker u_ltlb_checker (.*);
